// ===== rtl/rrwl_pkg.sv =====
`timescale 1ns / 1ps

package rrwl_pkg;

    // thread ids on the request port
    localparam int TID_W     = 3;
    localparam int TID_COUNT = 1 << TID_W;
    // depth fields on the result port
    localparam int DEPTH_W   = 16;

    typedef enum logic [1:0] {
        MODE_EXCL_LOCK   = 2'd0,
        MODE_EXCL_UNLOCK = 2'd1,
        MODE_SHR_LOCK    = 2'd2,
        MODE_SHR_UNLOCK  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [TID_W-1:0]   thread_id;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [DEPTH_W-1:0] exclusive_depth;
        logic [DEPTH_W-1:0] thread_shared_depth;
    } t_rsp;

    // state update controls from the decision logic to the lock state
    typedef struct packed {
        logic excl_we;
        logic owner_we;
        logic shr_we;
        logic total_inc;
        logic total_dec;
    } t_upd;

endpackage

// ===== rtl/recursive_reader_writer_lock.sv =====
`timescale 1ns / 1ps

// channel   | ports                     | beat taken when
// ----------+---------------------------+--------------------------------
// request   | i_start, o_busy, i_req    | i_start high and o_busy low
// result    | o_done, o_rsp             | o_done high (one cycle, no stall)
//
// one request beat per cycle, result beat after the request and result registers
// the rate is set by the read-modify-write of the lock state, read and written back in the same cycle
// o_busy stays low: the unit never refuses a request beat
// synchronous active-low reset clears all counts, owner and valids
// the receiver cannot stall; each result shows for exactly one cycle
module recursive_reader_writer_lock #(
    parameter int THREADS    = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rrwl_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output rrwl_pkg::t_rsp o_rsp
);

    // only thread ids that fit the request field can hold shared counts
    localparam int SLOTS   = (THREADS < rrwl_pkg::TID_COUNT) ? THREADS
                                                              : rrwl_pkg::TID_COUNT;
    // running total of all shared holds, wide enough for every count at max
    localparam int TOTAL_W = COUNT_BITS + $clog2(SLOTS);

    // request register
    logic           r_req_valid;
    rrwl_pkg::t_req r_req;

    // result register
    logic           r_done;
    rrwl_pkg::t_rsp r_rsp;

    // lock state as seen by the current request
    logic [COUNT_BITS-1:0]      st_mine;
    logic [TOTAL_W-1:0]         st_total;
    logic [rrwl_pkg::TID_W-1:0] st_owner;
    logic [COUNT_BITS-1:0]      st_excl;

    // decision outputs
    rrwl_pkg::t_status          dec_status;
    rrwl_pkg::t_upd             dec_upd;
    logic [COUNT_BITS-1:0]      n_excl;
    logic [COUNT_BITS-1:0]      n_mine;

    // zero-extended counts so the depth fields take the low bits at any width
    logic [COUNT_BITS+rrwl_pkg::DEPTH_W-1:0] excl_ext;
    logic [COUNT_BITS+rrwl_pkg::DEPTH_W-1:0] mine_ext;

    rrwl_pkg::t_rsp n_rsp;

    assign o_busy = 1'b0;

    // capture the request beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else begin
            r_req_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_req <= i_req;
        end
    end

    // lock state: shared counts, total, owner, exclusive nesting
    rrwl_state #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .TOTAL_W    (TOTAL_W)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_req_valid),
        .i_tid   (r_req.thread_id),
        .i_upd   (dec_upd),
        .i_excl  (n_excl),
        .i_mine  (n_mine),
        .o_mine  (st_mine),
        .o_total (st_total),
        .o_owner (st_owner),
        .o_excl  (st_excl)
    );

    // grant / deny decision and next counts
    rrwl_decide #(
        .THREADS    (THREADS),
        .COUNT_BITS (COUNT_BITS),
        .TOTAL_W    (TOTAL_W)
    ) u_decide (
        .i_req    (r_req),
        .i_mine   (st_mine),
        .i_total  (st_total),
        .i_owner  (st_owner),
        .i_excl   (st_excl),
        .o_status (dec_status),
        .o_upd    (dec_upd),
        .o_excl   (n_excl),
        .o_mine   (n_mine)
    );

    assign excl_ext = {{rrwl_pkg::DEPTH_W{1'b0}}, n_excl};
    assign mine_ext = {{rrwl_pkg::DEPTH_W{1'b0}}, n_mine};

    // result beat carries the counts after this request
    always_comb begin
        n_rsp.status              = dec_status;
        n_rsp.exclusive_depth     = excl_ext[rrwl_pkg::DEPTH_W-1:0];
        n_rsp.thread_shared_depth = mine_ext[rrwl_pkg::DEPTH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== rtl/rrwl_decide.sv =====
`timescale 1ns / 1ps

module rrwl_decide #(
    parameter int THREADS    = 8,
    parameter int COUNT_BITS = 16,
    parameter int TOTAL_W    = 19
) (
    input  rrwl_pkg::t_req                i_req,
    input  logic [COUNT_BITS-1:0]         i_mine,
    input  logic [TOTAL_W-1:0]            i_total,
    input  logic [rrwl_pkg::TID_W-1:0]    i_owner,
    input  logic [COUNT_BITS-1:0]         i_excl,
    output rrwl_pkg::t_status             o_status,
    output rrwl_pkg::t_upd                o_upd,
    output logic [COUNT_BITS-1:0]         o_excl,
    output logic [COUNT_BITS-1:0]         o_mine
);

    logic                  tid_ok;
    logic                  free_or_mine;
    logic [COUNT_BITS-1:0] mine_v;

    assign tid_ok       = (int'(i_req.thread_id) < THREADS);
    assign mine_v       = tid_ok ? i_mine : '0;
    assign free_or_mine = (i_excl == '0) || (i_owner == i_req.thread_id);

    always_comb begin
        o_status = rrwl_pkg::ST_OK;
        o_upd    = '0;
        o_excl   = i_excl;
        o_mine   = mine_v;
        if (!tid_ok) begin
            o_status = rrwl_pkg::ST_BUSY;
        end else begin
            unique case (i_req.mode)
                rrwl_pkg::MODE_EXCL_LOCK: begin
                    // other threads' shared holds block the writer
                    if ((i_total != TOTAL_W'(mine_v)) || !free_or_mine) begin
                        o_status = rrwl_pkg::ST_BUSY;
                    end else if (&i_excl) begin
                        o_status = rrwl_pkg::ST_OVER;
                    end else begin
                        o_upd.excl_we  = 1'b1;
                        o_upd.owner_we = 1'b1;
                        o_excl         = i_excl + COUNT_BITS'(1);
                    end
                end
                rrwl_pkg::MODE_EXCL_UNLOCK: begin
                    // owner not checked on release
                    if (i_excl == '0) begin
                        o_status = rrwl_pkg::ST_UNDER;
                    end else begin
                        o_upd.excl_we = 1'b1;
                        o_excl        = i_excl - COUNT_BITS'(1);
                    end
                end
                rrwl_pkg::MODE_SHR_LOCK: begin
                    if (!free_or_mine) begin
                        o_status = rrwl_pkg::ST_BUSY;
                    end else if (&mine_v) begin
                        o_status = rrwl_pkg::ST_OVER;
                    end else begin
                        o_upd.shr_we    = 1'b1;
                        o_upd.total_inc = 1'b1;
                        o_mine          = mine_v + COUNT_BITS'(1);
                    end
                end
                rrwl_pkg::MODE_SHR_UNLOCK: begin
                    if (mine_v == '0) begin
                        o_status = rrwl_pkg::ST_UNDER;
                    end else begin
                        o_upd.shr_we    = 1'b1;
                        o_upd.total_dec = 1'b1;
                        o_mine          = mine_v - COUNT_BITS'(1);
                    end
                end
                default: begin
                    o_status = rrwl_pkg::ST_BUSY;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rrwl_state.sv =====
`timescale 1ns / 1ps

module rrwl_state #(
    parameter int SLOTS      = 8,
    parameter int COUNT_BITS = 16,
    parameter int TOTAL_W    = 19
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [rrwl_pkg::TID_W-1:0]    i_tid,
    input  rrwl_pkg::t_upd                i_upd,
    input  logic [COUNT_BITS-1:0]         i_excl,
    input  logic [COUNT_BITS-1:0]         i_mine,
    output logic [COUNT_BITS-1:0]         o_mine,
    output logic [TOTAL_W-1:0]            o_total,
    output logic [rrwl_pkg::TID_W-1:0]    o_owner,
    output logic [COUNT_BITS-1:0]         o_excl
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [COUNT_BITS-1:0]      r_shared [SLOTS];
    logic [TOTAL_W-1:0]         r_total;
    logic [rrwl_pkg::TID_W-1:0] r_owner;
    logic [COUNT_BITS-1:0]      r_excl;
    logic [IDX_W-1:0]           idx;
    logic                       idx_ok;

    assign idx    = i_tid[IDX_W-1:0];
    assign idx_ok = (int'(i_tid) < SLOTS);
    assign o_mine = idx_ok ? r_shared[idx] : '0;
    assign o_total = r_total;
    assign o_owner = r_owner;
    assign o_excl  = r_excl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_shared[k] <= '0;
            end
            r_total <= '0;
            r_owner <= '0;
            r_excl  <= '0;
        end else if (i_en) begin
            if (i_upd.shr_we && idx_ok) begin
                r_shared[idx] <= i_mine;
            end
            if (i_upd.total_inc) begin
                r_total <= r_total + TOTAL_W'(1);
            end else if (i_upd.total_dec) begin
                r_total <= r_total - TOTAL_W'(1);
            end
            if (i_upd.owner_we) begin
                r_owner <= i_tid;
            end
            if (i_upd.excl_we) begin
                r_excl <= i_excl;
            end
        end
    end

endmodule

// ===== rtl/rrwl_checker.sv =====
`timescale 1ns / 1ps

module rrwl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_start,
    input rrwl_pkg::t_req i_req,
    input logic           o_busy,
    input logic           o_done,
    input rrwl_pkg::t_rsp o_rsp
);

    // every request beat gets its result beat after the request and result registers
    a_req_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("request beat without result");

    // no result without a request beat
    a_done_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy && i_rst_n, 2))
        else $error("result beat without request");

    // exclusive release underflow only when nesting is empty
    a_excl_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_req.mode, 2) == rrwl_pkg::MODE_EXCL_UNLOCK
         && o_rsp.status == rrwl_pkg::ST_UNDER) |-> (o_rsp.exclusive_depth == '0))
        else $error("exclusive underflow with nonzero depth");

    // shared release underflow only when the thread holds nothing
    a_shr_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_req.mode, 2) == rrwl_pkg::MODE_SHR_UNLOCK
         && o_rsp.status == rrwl_pkg::ST_UNDER) |-> (o_rsp.thread_shared_depth == '0))
        else $error("shared underflow with nonzero depth");

endmodule

bind recursive_reader_writer_lock rrwl_checker u_rrwl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_req   (i_req),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
